FILE: rtl/idg_pkg.sv
package idg_pkg;

  localparam int COORD_FRAC_BITS = 8;
  localparam int GAIN_FRAC_BITS  = 16;
  localparam int SAMPLE_W        = 16;
  localparam int COORD_W         = 16;
  localparam int DIFF_W          = COORD_W + 1;
  localparam int SQ_W            = 2 * COORD_W;
  localparam int SUM_W           = SQ_W + 2;
  localparam int ROOT_W          = (SUM_W + 1) / 2;
  localparam int GAIN_W          = GAIN_FRAC_BITS + 1;
  localparam int DIVISOR_W       = ROOT_W + 1;
  localparam int DIVIDEND_W      = GAIN_FRAC_BITS + COORD_FRAC_BITS + 1;
  localparam int QUOT_W          = DIVIDEND_W;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } frame_t;

endpackage

FILE: rtl/idg_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
module idg_sqrt_pipe (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [idg_pkg::SUM_W-1:0]              in_sum,
  input  idg_pkg::frame_t                        in_frame,
  output logic                                   out_valid,
  output logic [idg_pkg::ROOT_W-1:0]             out_root,
  output idg_pkg::frame_t                        out_frame
);

  localparam int N = idg_pkg::ROOT_W;
  localparam int RW = 2 * N;

  logic [N:0]                     vld;
  logic [RW-1:0]                  rem  [N+1];
  logic [N-1:0]                   root [N+1];
  idg_pkg::frame_t                frm  [N+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = RW'(in_sum);
  assign root[0] = '0;
  assign frm[0]  = in_frame;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int SH = 2 * (N - 1 - i);
    logic [RW-1:0] trial;
    logic          take;
    assign trial = ({{(RW-N){1'b0}}, root[i]} << (SH + 2)) | (RW'(1) << SH);
    assign take  = rem[i] >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1]  <= take ? rem[i] - trial : rem[i];
        root[i+1] <= {root[i][N-2:0], take};
        frm[i+1]  <= frm[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_root  = root[N];
  assign out_frame = frm[N];

endmodule

FILE: rtl/idg_div_pipe.sv
// Pipelined restoring divider for the gain, one quotient bit per stage.
module idg_div_pipe (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [idg_pkg::DIVISOR_W-1:0]          in_divisor,
  input  idg_pkg::frame_t                        in_frame,
  output logic                                   out_valid,
  output logic [idg_pkg::QUOT_W-1:0]             out_quot,
  output idg_pkg::frame_t                        out_frame
);

  localparam int Q = idg_pkg::QUOT_W;
  localparam int D = idg_pkg::DIVISOR_W;
  localparam logic [Q-1:0] DIVIDEND =
    Q'(1) << (idg_pkg::GAIN_FRAC_BITS + idg_pkg::COORD_FRAC_BITS);

  logic [Q:0]         vld;
  logic [D:0]         rem  [Q+1];
  logic [Q-1:0]       quot [Q+1];
  logic [D-1:0]       dvs  [Q+1];
  idg_pkg::frame_t    frm  [Q+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign quot[0] = '0;
  assign dvs[0]  = in_divisor;
  assign frm[0]  = in_frame;

  for (genvar i = 0; i < Q; i++) begin : g_stage
    logic [D+1:0] shifted;
    logic         take;
    assign shifted = {rem[i], DIVIDEND[Q-1-i]};
    assign take    = shifted >= {2'b00, dvs[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1]  <= take ? (D+1)'(shifted - {2'b00, dvs[i]}) : (D+1)'(shifted);
        quot[i+1] <= {quot[i][Q-2:0], take};
        dvs[i+1]  <= dvs[i];
        frm[i+1]  <= frm[i];
      end
    end
  end

  assign out_valid = vld[Q];
  assign out_quot  = quot[Q];
  assign out_frame = frm[Q];

endmodule

FILE: rtl/inverse_distance_gain.sv
// Stages in order: differences, squares, sum, one square-root bit per stage,
// one quotient bit per stage, the sample multiply and the sign fix.
// Throughput: one word per cycle while the output is not stalled; every stage
// is a pipeline register set.
// Reset (rst, synchronous, active high) clears all valid bits; data is not reset.
// The whole pipeline advances only when the output register is empty or taken.
module inverse_distance_gain (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // Fields from bit 0: left_in, right_in, source_x, source_y, source_z,
  // listener_x, listener_y, listener_z.
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // Fields from bit 0: left_out[15:0], right_out[31:16], gain[48:32], zero pad.
  output logic [55:0]  m_tdata
);

  localparam int CW = idg_pkg::COORD_W;
  localparam int DW = idg_pkg::DIFF_W;
  localparam int SW = idg_pkg::SAMPLE_W;
  localparam int GW = idg_pkg::GAIN_W;
  localparam int PW = SW + GW;

  // The pipeline moves as one; a stall freezes every stage at once, so no
  // item is lost or repeated. The final register is the output register.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  idg_pkg::frame_t fin;
  assign fin.left  = s_tdata[15:0];
  assign fin.right = s_tdata[31:16];

  // Stage 1: coordinate differences.
  logic                 v1;
  logic signed [DW-1:0] dx, dy, dz;
  idg_pkg::frame_t      f1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
    if (en) begin
      dx <= DW'($signed(s_tdata[47:32]))  - DW'($signed(s_tdata[95:80]));
      dy <= DW'($signed(s_tdata[63:48]))  - DW'($signed(s_tdata[111:96]));
      dz <= DW'($signed(s_tdata[79:64]))  - DW'($signed(s_tdata[127:112]));
      f1 <= fin;
    end
  end

  // Stage 2: squares of the magnitudes (each at most 2^32).
  logic [CW-1+1:0]      ax, ay, az;
  assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign az = dz[DW-1] ? DW'(-dz) : DW'(dz);

  logic                           v2;
  logic [idg_pkg::SQ_W:0]         sqx, sqy, sqz;
  idg_pkg::frame_t                f2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      sqx <= (idg_pkg::SQ_W+1)'(ax * ax);
      sqy <= (idg_pkg::SQ_W+1)'(ay * ay);
      sqz <= (idg_pkg::SQ_W+1)'(az * az);
      f2  <= f1;
    end
  end

  // Stage 3: sum of squares.
  logic                       v3;
  logic [idg_pkg::SUM_W-1:0]  sum;
  idg_pkg::frame_t            f3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      sum <= idg_pkg::SUM_W'(sqx) + idg_pkg::SUM_W'(sqy) + idg_pkg::SUM_W'(sqz);
      f3  <= f2;
    end
  end

  // Square root, then gain = 2^(G+C) / (2^C + root).
  logic                          vr;
  logic [idg_pkg::ROOT_W-1:0]    root;
  idg_pkg::frame_t               fr;
  idg_sqrt_pipe u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3), .in_sum(sum), .in_frame(f3),
    .out_valid(vr), .out_root(root), .out_frame(fr)
  );

  logic [idg_pkg::DIVISOR_W-1:0] divisor;
  assign divisor = idg_pkg::DIVISOR_W'(root) +
                   (idg_pkg::DIVISOR_W'(1) << idg_pkg::COORD_FRAC_BITS);

  logic                          vq;
  logic [idg_pkg::QUOT_W-1:0]    quot;
  idg_pkg::frame_t               fq;
  idg_div_pipe u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vr), .in_divisor(divisor), .in_frame(fr),
    .out_valid(vq), .out_quot(quot), .out_frame(fq)
  );

  logic [GW-1:0] gain_q;
  assign gain_q = GW'(quot);

  // Multiply stage: magnitude times gain.
  logic [SW:0] ml, mr;
  assign ml = fq.left[SW-1]  ? (SW+1)'(-$signed({fq.left[SW-1], fq.left}))
                             : (SW+1)'(fq.left);
  assign mr = fq.right[SW-1] ? (SW+1)'(-$signed({fq.right[SW-1], fq.right}))
                             : (SW+1)'(fq.right);

  logic            vm, sl, sr;
  logic [PW:0]     pl, pr;
  logic [GW-1:0]   gm;
  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (en) vm <= vq;
    if (en) begin
      pl <= (PW+1)'(ml * gain_q);
      pr <= (PW+1)'(mr * gain_q);
      sl <= fq.left[SW-1];
      sr <= fq.right[SW-1];
      gm <= gain_q;
    end
  end

  // Output register: shift, restore the sign.
  logic [SW-1:0] ql, qr;
  assign ql = SW'(pl >> idg_pkg::GAIN_FRAC_BITS);
  assign qr = SW'(pr >> idg_pkg::GAIN_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= vm;
    if (en) begin
      m_tdata <= {7'b0, gm, (sr ? SW'(-qr) : qr), (sl ? SW'(-ql) : ql)};
    end
  end

  // The gain never exceeds one.
  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[48:32] <= 17'd65536)
    else $error("gain above unity");
  // A stalled word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output word changed while stalled");
  // The pad bits above the gain stay zero.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[55:49] == 7'd0)
    else $error("pad bits set");

endmodule
